// ===== src/vpsa_pkg.sv =====
`timescale 1ns / 1ps

package vpsa_pkg;

	localparam int COORD_BITS   = 32;
	localparam int NUM_PARAMS   = 6;
	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);

	localparam int S_TUSER_BITS = 6;
	localparam int S_FIELD_BITS = NUM_PARAMS * COORD_BITS + 2;
	localparam int S_TDATA_BITS = ((S_FIELD_BITS + 7) / 8) * 8;
	localparam int M_TUSER_BITS = 4;
	localparam int M_FIELD_BITS = 8 * COORD_BITS + 2;
	localparam int M_TDATA_BITS = ((M_FIELD_BITS + 7) / 8) * 8;
	localparam int M_PAD_BITS   = M_TDATA_BITS - M_FIELD_BITS;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

	typedef enum logic [3:0] {
		CMD_MOVE  = 4'd0,
		CMD_LINE  = 4'd1,
		CMD_HORIZ = 4'd2,
		CMD_VERT  = 4'd3,
		CMD_CUBIC = 4'd4,
		CMD_SMOOTH_CUBIC = 4'd5,
		CMD_QUAD  = 4'd6,
		CMD_SMOOTH_QUAD  = 4'd7,
		CMD_ARC   = 4'd8,
		CMD_CLOSE = 4'd9
	} cmd_t;

	typedef enum logic [2:0] {
		KIND_MOVE  = 3'd0,
		KIND_LINE  = 3'd1,
		KIND_CUBIC = 3'd2,
		KIND_QUAD  = 3'd3,
		KIND_ARC   = 3'd4,
		KIND_CLOSE = 3'd5
	} seg_kind_t;

	typedef struct packed {
		logic                          path_start;
		cmd_t                          cmd;
		seg_kind_t                     kind;
		logic                          bad_cmd;
		logic                          neg_radius;
		logic [NUM_PARAMS-1:0]         add_x;
		logic [NUM_PARAMS-1:0]         add_y;
		logic [NUM_PARAMS-1:0][COORD_BITS-1:0] prm;
		logic                          big_arc;
		logic                          sweep;
	} item_t;

	function automatic coord_t sat_add(coord_t a, coord_t b);
		logic [COORD_BITS:0] s;
		s = {a[COORD_BITS-1], a} + {b[COORD_BITS-1], b};
		if (s[COORD_BITS] != s[COORD_BITS-1])
			sat_add = s[COORD_BITS] ? COORD_MIN : COORD_MAX;
		else
			sat_add = s[COORD_BITS-1:0];
	endfunction

	function automatic coord_t sat_sub(coord_t a, coord_t b);
		logic [COORD_BITS:0] s;
		s = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
		if (s[COORD_BITS] != s[COORD_BITS-1])
			sat_sub = s[COORD_BITS] ? COORD_MIN : COORD_MAX;
		else
			sat_sub = s[COORD_BITS-1:0];
	endfunction

	function automatic coord_t reflect(coord_t cur, coord_t last);
		reflect = sat_add(cur, sat_sub(cur, last));
	endfunction

endpackage

// ===== src/vector_path_segment_absolutizer_unit.sv =====
`timescale 1ns / 1ps

// Path segment absolutizer: one tokenised path command in, one absolute segment out.
// Slave channel carries one command per beat: tuser holds path_start, the command
// code and the relative flag; tdata holds the six Q16.16 parameters and the two arc
// flags. Master channel carries one segment per beat: tuser holds the segment kind
// and the sticky path error; tdata holds start, both control points, end and the
// arc flags. Every command gives exactly one segment, in order.
// A front stage decodes each beat and writes it to a two-entry queue; the back stage
// holds the current point, subpath start and last control points, works out one
// segment per cycle unless the receiver stalls, and loads it into the output register.
// An accepted beat is written to a queue entry and is then taken from the queue head
// into the output register once that register is free or being read.
// Throughput: one command per cycle while the receiver does not stall; the back stage
// updates the current point with each command that it takes.
// Reset empties the queue and clears the output valid, and puts the path state in the
// awaiting-first-move condition. When the receiver stalls, the output register holds
// its beat, the queue fills, and tready drops once both queue entries are taken.

module vector_path_segment_absolutizer_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// param_a, param_b, param_c, param_d, param_e, param_f, large_arc_in, sweep_in
	input  logic [vpsa_pkg::S_TDATA_BITS-1:0] s_tdata,
	// path_start, cmd[3:0], relative
	input  logic [vpsa_pkg::S_TUSER_BITS-1:0] s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// seg_start_x, seg_start_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, seg_end_x,
	// seg_end_y, large_arc_out, sweep_out
	output logic [vpsa_pkg::M_TDATA_BITS-1:0] m_tdata,
	// seg_kind[2:0], path_error
	output logic [vpsa_pkg::M_TUSER_BITS-1:0] m_tuser
);

	logic            q_full, q_push, q_pop, q_not_empty;
	vpsa_pkg::item_t push_item, head_item;

	vpsa_front u_front (
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.q_full    (q_full),
		.push      (q_push),
		.push_item (push_item)
	);

	vpsa_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head_item (head_item)
	);

	vpsa_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_not_empty),
		.hd         (head_item),
		.pop        (q_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

endmodule

// ===== src/vpsa_front.sv =====
`timescale 1ns / 1ps

module vpsa_front (
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [vpsa_pkg::S_TDATA_BITS-1:0]   s_tdata,  // param_a..param_f, large_arc_in, sweep_in
	input  logic [vpsa_pkg::S_TUSER_BITS-1:0]   s_tuser,  // path_start, cmd[3:0], relative
	input  logic                                q_full,
	output logic                                push,
	output vpsa_pkg::item_t                     push_item
);

	logic rel;

	assign s_tready = !q_full;
	assign push     = s_tvalid && !q_full;
	assign rel      = s_tuser[5];

	always_comb begin
		push_item            = '0;
		push_item.path_start = s_tuser[0];
		push_item.cmd        = vpsa_pkg::cmd_t'(s_tuser[4:1]);
		push_item.bad_cmd    = s_tuser[4:1] > vpsa_pkg::CMD_CLOSE;
		for (int i = 0; i < vpsa_pkg::NUM_PARAMS; i++)
			push_item.prm[i] = s_tdata[i*vpsa_pkg::COORD_BITS +: vpsa_pkg::COORD_BITS];
		push_item.big_arc    = s_tdata[vpsa_pkg::NUM_PARAMS*vpsa_pkg::COORD_BITS];
		push_item.sweep      = s_tdata[vpsa_pkg::NUM_PARAMS*vpsa_pkg::COORD_BITS + 1];
		push_item.kind       = vpsa_pkg::KIND_CLOSE;
		case (push_item.cmd)
			vpsa_pkg::CMD_MOVE, vpsa_pkg::CMD_LINE: begin
				push_item.kind     = (push_item.cmd == vpsa_pkg::CMD_MOVE) ?
					vpsa_pkg::KIND_MOVE : vpsa_pkg::KIND_LINE;
				push_item.add_x[0] = rel;
				push_item.add_y[1] = rel;
			end
			vpsa_pkg::CMD_HORIZ: begin
				push_item.kind     = vpsa_pkg::KIND_LINE;
				push_item.add_x[0] = rel;
			end
			vpsa_pkg::CMD_VERT: begin
				push_item.kind     = vpsa_pkg::KIND_LINE;
				push_item.add_y[0] = rel;
			end
			vpsa_pkg::CMD_CUBIC: begin
				push_item.kind = vpsa_pkg::KIND_CUBIC;
				for (int i = 0; i < vpsa_pkg::NUM_PARAMS; i += 2) begin
					push_item.add_x[i]   = rel;
					push_item.add_y[i+1] = rel;
				end
			end
			vpsa_pkg::CMD_SMOOTH_CUBIC, vpsa_pkg::CMD_QUAD: begin
				push_item.kind     = (push_item.cmd == vpsa_pkg::CMD_QUAD) ?
					vpsa_pkg::KIND_QUAD : vpsa_pkg::KIND_CUBIC;
				push_item.add_x[0] = rel;
				push_item.add_y[1] = rel;
				push_item.add_x[2] = rel;
				push_item.add_y[3] = rel;
			end
			vpsa_pkg::CMD_SMOOTH_QUAD: begin
				push_item.kind     = vpsa_pkg::KIND_QUAD;
				push_item.add_x[0] = rel;
				push_item.add_y[1] = rel;
			end
			vpsa_pkg::CMD_ARC: begin
				push_item.kind       = vpsa_pkg::KIND_ARC;
				push_item.add_x[3]   = rel;
				push_item.add_y[4]   = rel;
				push_item.neg_radius = push_item.prm[0][vpsa_pkg::COORD_BITS-1] ||
					push_item.prm[1][vpsa_pkg::COORD_BITS-1];
			end
			default: begin
				push_item.kind = vpsa_pkg::KIND_CLOSE;
			end
		endcase
	end

endmodule

// ===== src/vpsa_queue.sv =====
`timescale 1ns / 1ps

module vpsa_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  vpsa_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output vpsa_pkg::item_t head_item
);

	vpsa_pkg::item_t                     entry_q [vpsa_pkg::QUEUE_DEPTH];
	logic [vpsa_pkg::QPTR_BITS-1:0]      wr_ptr_q;
	logic [vpsa_pkg::QPTR_BITS-1:0]      rd_ptr_q;
	logic [vpsa_pkg::QCNT_BITS-1:0]      count_q;

	assign full      = count_q == vpsa_pkg::QCNT_BITS'(vpsa_pkg::QUEUE_DEPTH);
	assign not_empty = count_q != '0;
	assign head_item = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == vpsa_pkg::QPTR_BITS'(vpsa_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == vpsa_pkg::QPTR_BITS'(vpsa_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== src/vpsa_back.sv =====
`timescale 1ns / 1ps

module vpsa_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              head_valid,
	input  vpsa_pkg::item_t                   hd,
	output logic                              pop,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [vpsa_pkg::M_TDATA_BITS-1:0] m_tdata,
	output logic [vpsa_pkg::M_TUSER_BITS-1:0] m_tuser
);

	vpsa_pkg::coord_t cur_x_q, cur_y_q, sub_x_q, sub_y_q;
	vpsa_pkg::coord_t cubic_x_q, cubic_y_q, quad_x_q, quad_y_q;
	logic             cubic_valid_q, quad_valid_q, await_q, err_q;

	logic             m_tvalid_q;
	logic [vpsa_pkg::M_TDATA_BITS-1:0] m_tdata_q;
	logic [vpsa_pkg::M_TUSER_BITS-1:0] m_tuser_q;

	vpsa_pkg::coord_t sx, sy, sub_x, sub_y;
	logic             cv, qv, await_first, err_prev, err_new;
	vpsa_pkg::coord_t p [vpsa_pkg::NUM_PARAMS];
	vpsa_pkg::coord_t c1x, c1y, c2x, c2y, ex, ey;
	logic             la, sw;

	assign pop = head_valid && (!m_tvalid_q || m_tready);

	always_comb begin
		sx          = hd.path_start ? '0 : cur_x_q;
		sy          = hd.path_start ? '0 : cur_y_q;
		sub_x       = hd.path_start ? '0 : sub_x_q;
		sub_y       = hd.path_start ? '0 : sub_y_q;
		cv          = !hd.path_start && cubic_valid_q;
		qv          = !hd.path_start && quad_valid_q;
		await_first = hd.path_start || await_q;
		err_prev    = !hd.path_start && err_q;
		err_new     = err_prev || hd.bad_cmd || hd.neg_radius ||
			(await_first && hd.cmd != vpsa_pkg::CMD_MOVE);
		for (int i = 0; i < vpsa_pkg::NUM_PARAMS; i++) begin
			if (hd.add_x[i])
				p[i] = vpsa_pkg::sat_add(hd.prm[i], sx);
			else if (hd.add_y[i])
				p[i] = vpsa_pkg::sat_add(hd.prm[i], sy);
			else
				p[i] = hd.prm[i];
		end
	end

	always_comb begin
		c1x = '0;
		c1y = '0;
		c2x = '0;
		c2y = '0;
		ex  = sx;
		ey  = sy;
		la  = 1'b0;
		sw  = 1'b0;
		case (hd.cmd)
			vpsa_pkg::CMD_MOVE, vpsa_pkg::CMD_LINE: begin
				ex = p[0];
				ey = p[1];
			end
			vpsa_pkg::CMD_HORIZ: begin
				ex = p[0];
			end
			vpsa_pkg::CMD_VERT: begin
				ey = p[0];
			end
			vpsa_pkg::CMD_CUBIC: begin
				c1x = p[0];
				c1y = p[1];
				c2x = p[2];
				c2y = p[3];
				ex  = p[4];
				ey  = p[5];
			end
			vpsa_pkg::CMD_SMOOTH_CUBIC: begin
				c1x = cv ? vpsa_pkg::reflect(sx, cubic_x_q) : sx;
				c1y = cv ? vpsa_pkg::reflect(sy, cubic_y_q) : sy;
				c2x = p[0];
				c2y = p[1];
				ex  = p[2];
				ey  = p[3];
			end
			vpsa_pkg::CMD_QUAD: begin
				c1x = p[0];
				c1y = p[1];
				ex  = p[2];
				ey  = p[3];
			end
			vpsa_pkg::CMD_SMOOTH_QUAD: begin
				c1x = qv ? vpsa_pkg::reflect(sx, quad_x_q) : sx;
				c1y = qv ? vpsa_pkg::reflect(sy, quad_y_q) : sy;
				ex  = p[0];
				ey  = p[1];
			end
			vpsa_pkg::CMD_ARC: begin
				c1x = p[0];
				c1y = p[1];
				c2x = p[2];
				ex  = p[3];
				ey  = p[4];
				la  = hd.big_arc;
				sw  = hd.sweep;
			end
			default: begin
				ex = sub_x;
				ey = sub_y;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q       <= '0;
			cur_y_q       <= '0;
			sub_x_q       <= '0;
			sub_y_q       <= '0;
			cubic_valid_q <= 1'b0;
			quad_valid_q  <= 1'b0;
			await_q       <= 1'b1;
			err_q         <= 1'b0;
		end else if (pop) begin
			err_q <= err_new;
			if (!err_new) begin
				cur_x_q       <= ex;
				cur_y_q       <= ey;
				if (hd.kind == vpsa_pkg::KIND_MOVE) begin
					sub_x_q <= ex;
					sub_y_q <= ey;
				end
				cubic_valid_q <= hd.kind == vpsa_pkg::KIND_CUBIC;
				quad_valid_q  <= hd.kind == vpsa_pkg::KIND_QUAD;
				await_q       <= 1'b0;
			end else if (hd.path_start) begin
				cur_x_q       <= '0;
				cur_y_q       <= '0;
				sub_x_q       <= '0;
				sub_y_q       <= '0;
				cubic_valid_q <= 1'b0;
				quad_valid_q  <= 1'b0;
				await_q       <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && !err_new) begin
			if (hd.kind == vpsa_pkg::KIND_CUBIC) begin
				cubic_x_q <= c2x;
				cubic_y_q <= c2y;
			end
			if (hd.kind == vpsa_pkg::KIND_QUAD) begin
				quad_x_q <= c1x;
				quad_y_q <= c1y;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (pop)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (err_new) begin
				m_tdata_q <= '0;
				m_tuser_q <= {1'b1, 3'(vpsa_pkg::KIND_MOVE)};
			end else begin
				m_tdata_q <= {{vpsa_pkg::M_PAD_BITS{1'b0}}, sw, la, ey, ex, c2y, c2x,
					c1y, c1x, sy, sx};
				m_tuser_q <= {1'b0, hd.kind};
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

// ===== src/vpsa_checker.sv =====
`timescale 1ns / 1ps

module vpsa_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [vpsa_pkg::M_TDATA_BITS-1:0] m_tdata,
	input logic [vpsa_pkg::M_TUSER_BITS-1:0] m_tuser
);

	localparam int CB = vpsa_pkg::COORD_BITS;

	// hold a stalled beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled output beat changed");

	// an error beat carries nothing else
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[3] |-> m_tdata == '0 && m_tuser[2:0] == '0)
		else $error("error beat with non-zero fields");

	// arc flags and second control y are zero on every kind but arcs and cubics
	a_unused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2:0] != vpsa_pkg::KIND_ARC && m_tuser[2:0] != vpsa_pkg::KIND_CUBIC
		|-> m_tdata[8*CB+1:8*CB] == '0 && m_tdata[6*CB-1:5*CB] == '0)
		else $error("unused segment field not zero");

	// input back-pressure only follows an output stall
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> $past(m_tvalid && !m_tready))
		else $error("input stalled without output stall");

endmodule

bind vector_path_segment_absolutizer_unit vpsa_checker u_vpsa_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ===== tb/sv/path_check_pkg.sv =====
`timescale 1ns / 1ps

package path_check_pkg;

	import vpsa_pkg::*;

	localparam logic [3:0] CMD_BAD_FIRST = 4'd10;
	localparam logic [3:0] CMD_BAD_LAST  = 4'd15;

	localparam int NUM_POINTS = 8;

	typedef struct packed {
		logic                                  path_start;
		logic [3:0]                            cmd;
		logic                                  relative;
		logic [NUM_PARAMS-1:0][COORD_BITS-1:0] prm;
		logic                                  big_arc;
		logic                                  sweep;
	} command_t;

	// pts from index 0 up: start x/y, ctrl1 x/y, ctrl2 x/y, end x/y
	typedef struct packed {
		seg_kind_t                             kind;
		logic [NUM_POINTS-1:0][COORD_BITS-1:0] pts;
		logic                                  big_arc;
		logic                                  sweep;
		logic                                  path_error;
	} segment_t;

	class path_scoreboard;
		coord_t cur_x, cur_y, sub_x, sub_y;
		coord_t cub_x, cub_y, quad_x, quad_y;
		bit cub_ok, quad_ok, need_move, sticky_err;
		segment_t due[$];
		int unsigned failures;

		function new();
			failures = 0;
			clear_path();
		endfunction

		function void clear_path();
			cur_x = '0;
			cur_y = '0;
			sub_x = '0;
			sub_y = '0;
			cub_x = '0;
			cub_y = '0;
			quad_x = '0;
			quad_y = '0;
			cub_ok = 1'b0;
			quad_ok = 1'b0;
			need_move = 1'b1;
			sticky_err = 1'b0;
		endfunction

		static function coord_t clip(longint v);
			if (v > longint'(COORD_MAX))
				return COORD_MAX;
			if (v < longint'(COORD_MIN))
				return COORD_MIN;
			return coord_t'(v);
		endfunction

		static function coord_t offset(coord_t a, coord_t o);
			return clip(longint'(a) + longint'(o));
		endfunction

		static function coord_t mirror(coord_t cur, coord_t last);
			return offset(cur, clip(longint'(cur) - longint'(last)));
		endfunction

		function segment_t absolutize(command_t c);
			segment_t s;
			coord_t p [NUM_PARAMS];
			coord_t ox, oy, c1x, c1y, c2x, c2y, ex, ey;
			s = '0;
			if (c.path_start)
				clear_path();
			for (int i = 0; i < NUM_PARAMS; i++)
				p[i] = coord_t'(c.prm[i]);
			if (!sticky_err) begin
				if (c.cmd > CMD_CLOSE || (need_move && c.cmd != CMD_MOVE))
					sticky_err = 1'b1;
				else if (c.cmd == CMD_ARC && (p[0] < 0 || p[1] < 0))
					sticky_err = 1'b1;
			end
			if (sticky_err) begin
				s.path_error = 1'b1;
				return s;
			end
			ox = c.relative ? cur_x : coord_t'(0);
			oy = c.relative ? cur_y : coord_t'(0);
			c1x = '0;
			c1y = '0;
			c2x = '0;
			c2y = '0;
			ex = cur_x;
			ey = cur_y;
			case (c.cmd)
				CMD_MOVE, CMD_LINE: begin
					s.kind = (c.cmd == CMD_MOVE) ? KIND_MOVE : KIND_LINE;
					ex = offset(p[0], ox);
					ey = offset(p[1], oy);
				end
				CMD_HORIZ: begin
					s.kind = KIND_LINE;
					ex = offset(p[0], ox);
				end
				CMD_VERT: begin
					s.kind = KIND_LINE;
					ey = offset(p[0], oy);
				end
				CMD_CUBIC: begin
					s.kind = KIND_CUBIC;
					c1x = offset(p[0], ox);
					c1y = offset(p[1], oy);
					c2x = offset(p[2], ox);
					c2y = offset(p[3], oy);
					ex = offset(p[4], ox);
					ey = offset(p[5], oy);
				end
				CMD_SMOOTH_CUBIC: begin
					s.kind = KIND_CUBIC;
					c1x = cub_ok ? mirror(cur_x, cub_x) : cur_x;
					c1y = cub_ok ? mirror(cur_y, cub_y) : cur_y;
					c2x = offset(p[0], ox);
					c2y = offset(p[1], oy);
					ex = offset(p[2], ox);
					ey = offset(p[3], oy);
				end
				CMD_QUAD: begin
					s.kind = KIND_QUAD;
					c1x = offset(p[0], ox);
					c1y = offset(p[1], oy);
					ex = offset(p[2], ox);
					ey = offset(p[3], oy);
				end
				CMD_SMOOTH_QUAD: begin
					s.kind = KIND_QUAD;
					c1x = quad_ok ? mirror(cur_x, quad_x) : cur_x;
					c1y = quad_ok ? mirror(cur_y, quad_y) : cur_y;
					ex = offset(p[0], ox);
					ey = offset(p[1], oy);
				end
				CMD_ARC: begin
					s.kind = KIND_ARC;
					c1x = p[0];
					c1y = p[1];
					c2x = p[2];
					ex = offset(p[3], ox);
					ey = offset(p[4], oy);
					s.big_arc = c.big_arc;
					s.sweep = c.sweep;
				end
				default: begin
					s.kind = KIND_CLOSE;
					ex = sub_x;
					ey = sub_y;
				end
			endcase
			s.pts = {ey, ex, c2y, c2x, c1y, c1x, cur_y, cur_x};
			cur_x = ex;
			cur_y = ey;
			if (s.kind == KIND_MOVE) begin
				sub_x = ex;
				sub_y = ey;
			end
			cub_ok = (s.kind == KIND_CUBIC);
			quad_ok = (s.kind == KIND_QUAD);
			if (cub_ok) begin
				cub_x = c2x;
				cub_y = c2y;
			end
			if (quad_ok) begin
				quad_x = c1x;
				quad_y = c1y;
			end
			need_move = 1'b0;
			return s;
		endfunction

		function void note_command(command_t c);
			due = {due, absolutize(c)};
		endfunction

		function int unsigned pending();
			return due.size();
		endfunction

		function void compare(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
				failures++;
			end
		endfunction

		function void check_segment(segment_t got);
			segment_t want;
			string names [NUM_POINTS];
			names = '{"seg_start_x", "seg_start_y", "ctrl1_x", "ctrl1_y",
				"ctrl2_x", "ctrl2_y", "seg_end_x", "seg_end_y"};
			if (due.size() == 0) begin
				$display("%0t: segment with no command pending, kind %0d error %0b",
					$time, got.kind, got.path_error);
				failures++;
				return;
			end
			want = due.pop_front();
			compare("seg_kind", want.kind, got.kind);
			for (int i = 0; i < NUM_POINTS; i++)
				compare(names[i], want.pts[i], got.pts[i]);
			compare("large_arc_out", want.big_arc, got.big_arc);
			compare("sweep_out", want.sweep, got.sweep);
			compare("path_error", want.path_error, got.path_error);
		endfunction
	endclass

endpackage

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

	import vpsa_pkg::*;
	import path_check_pkg::*;

	localparam int RANDOM_ITEMS   = 1850;
	localparam int STEADY_TAIL    = 200;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 8;

	logic                    clk;
	logic                    arst_n = 1'b0;
	logic                    s_tvalid = 1'b0;
	logic                    s_tready;
	logic [S_TDATA_BITS-1:0] s_tdata = '0;
	logic [S_TUSER_BITS-1:0] s_tuser = '0;
	logic                    m_tvalid;
	logic                    m_tready = 1'b0;
	logic [M_TDATA_BITS-1:0] m_tdata;
	logic [M_TUSER_BITS-1:0] m_tuser;

	path_scoreboard sb;
	bit             steady = 1'b0;
	int unsigned    gap_pct = 30;
	int unsigned    stall_pct = 30;
	int unsigned    quiet_cycles;

	vector_path_segment_absolutizer_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic coord_t q16(int whole);
		return coord_t'(whole * 65536);
	endfunction

	function automatic coord_t pick_coord();
		case ($urandom_range(0, 9))
			0, 1: return coord_t'($urandom);
			2: return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
			3: return coord_t'($signed($urandom_range(0, 4)) - 2);
			default: return coord_t'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
		endcase
	endfunction

	function automatic coord_t pick_radius();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return COORD_MAX;
			2, 3: return coord_t'($urandom & 32'h7FFF_FFFF);
			default: return coord_t'($urandom_range(0, 32'h00FF_FFFF));
		endcase
	endfunction

	function automatic command_t random_command(bit opening);
		command_t c;
		int unsigned roll;
		roll = $urandom_range(0, 99);
		for (int i = 0; i < NUM_PARAMS; i++)
			c.prm[i] = pick_coord();
		c.path_start = opening;
		c.relative = $urandom_range(0, 1);
		c.big_arc = $urandom_range(0, 1);
		c.sweep = $urandom_range(0, 1);
		if (opening)
			c.cmd = (roll < 4) ? 4'($urandom_range(CMD_LINE, CMD_CLOSE)) : CMD_MOVE;
		else if (roll < 2)
			c.cmd = 4'($urandom_range(CMD_BAD_FIRST, CMD_BAD_LAST));
		else
			c.cmd = 4'($urandom_range(CMD_MOVE, CMD_CLOSE));
		if (c.cmd == CMD_ARC) begin
			c.prm[0] = pick_radius();
			c.prm[1] = pick_radius();
			if (roll >= 90)
				c.prm[$urandom_range(0, 1)] = coord_t'($urandom | 32'h8000_0000);
		end
		return c;
	endfunction

	task automatic send_command(input command_t c);
		if (!steady && $urandom_range(0, 99) < gap_pct) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		s_tdata = {{(S_TDATA_BITS - S_FIELD_BITS){1'b0}}, c.sweep, c.big_arc, c.prm};
		s_tuser = {c.relative, c.cmd, c.path_start};
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		sb.note_command(c);
		@(negedge clk);
	endtask

	task automatic send_fields(input bit start, input logic [3:0] cmd, input bit rel,
		input coord_t a, input coord_t b, input coord_t c = '0, input coord_t d = '0,
		input coord_t e = '0, input coord_t f = '0, input bit la = 1'b0, input bit sw = 1'b0);
		command_t item;
		item.path_start = start;
		item.cmd = cmd;
		item.relative = rel;
		item.prm = {f, e, d, c, b, a};
		item.big_arc = la;
		item.sweep = sw;
		send_command(item);
	endtask

	task automatic wait_for_segments();
		s_tvalid = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	always @(posedge clk) begin
		segment_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.kind = seg_kind_t'(m_tuser[2:0]);
			got.path_error = m_tuser[3];
			got.pts = m_tdata[NUM_POINTS*COORD_BITS-1:0];
			got.big_arc = m_tdata[NUM_POINTS*COORD_BITS];
			got.sweep = m_tdata[NUM_POINTS*COORD_BITS+1];
			sb.check_segment(got);
		end
	end

	initial begin
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 255) == 0)
				stall_pct = 25 * $urandom_range(0, 2);
			if (!steady && $urandom_range(0, 99) < stall_pct) begin
				m_tready = 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
			end
			m_tready = 1'b1;
		end
	end

	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("vector_path_segment_absolutizer_unit test failed");
		$finish;
	end

	initial begin
		int unsigned sent;
		int unsigned path_len;
		bit paused;
		sb = new();
		sent = 0;
		paused = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// no opening move: error sticks through close
		send_fields(0, CMD_LINE, 0, q16(1), q16(2));
		send_fields(0, CMD_CLOSE, 0, '0, '0);
		send_fields(1, CMD_MOVE, 0, q16(10), q16(20));
		send_fields(0, CMD_LINE, 1, q16(3), -q16(4));
		// smooth curves with no previous control point
		send_fields(0, CMD_SMOOTH_CUBIC, 0, q16(5), q16(6), q16(7), q16(8));
		send_fields(0, CMD_SMOOTH_QUAD, 1, q16(1), q16(1));
		send_fields(0, CMD_HORIZ, 0, COORD_MAX, '0);
		send_fields(0, CMD_VERT, 1, COORD_MAX, '0);
		send_fields(0, CMD_CUBIC, 0, COORD_MIN, COORD_MIN, -q16(2), q16(9), q16(1), q16(1));
		send_fields(0, CMD_SMOOTH_CUBIC, 1, COORD_MIN, COORD_MAX, -q16(3), q16(2));
		send_fields(0, CMD_SMOOTH_CUBIC, 0, COORD_MAX, COORD_MIN, '0, '0);
		send_fields(0, CMD_QUAD, 1, q16(100), -q16(100), q16(5), q16(5));
		send_fields(0, CMD_SMOOTH_QUAD, 0, COORD_MIN, COORD_MAX);
		send_fields(0, CMD_SMOOTH_QUAD, 1, coord_t'(-1), coord_t'(1));
		send_fields(0, CMD_HORIZ, 1, COORD_MIN, '0);
		send_fields(0, CMD_ARC, 0, '0, '0, coord_t'(-1), q16(4), q16(4), '0, 1, 1);
		send_fields(0, CMD_ARC, 1, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN,
			coord_t'(-1), 1, 0);
		send_fields(0, CMD_CLOSE, 1, coord_t'(-1), coord_t'(-1), coord_t'(-1), coord_t'(-1),
			coord_t'(-1), coord_t'(-1), 1, 1);
		send_fields(0, CMD_MOVE, 1, COORD_MAX, COORD_MIN);
		send_fields(0, CMD_ARC, 0, coord_t'(-1), q16(1), '0, '0, '0);
		send_fields(0, CMD_LINE, 0, '0, '0);
		send_fields(1, CMD_CLOSE, 0, '0, '0);
		send_fields(1, CMD_MOVE, 1, COORD_MIN, COORD_MIN);
		send_fields(0, CMD_BAD_LAST, 1, q16(1), q16(1));
		send_fields(1, CMD_MOVE, 0, coord_t'(-1), coord_t'(-1));
		send_fields(0, CMD_BAD_FIRST, 0, '0, '0);

		while (sent < RANDOM_ITEMS) begin
			path_len = $urandom_range(1, 24);
			gap_pct = 20 * $urandom_range(0, 3);
			for (int k = 0; k < path_len && sent < RANDOM_ITEMS; k++) begin
				steady = (RANDOM_ITEMS - sent) <= STEADY_TAIL;
				send_command(random_command(k == 0));
				sent++;
			end
			if (!paused && sent >= RANDOM_ITEMS / 2) begin
				wait_for_segments();
				paused = 1'b1;
			end
		end

		wait_for_segments();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.failures == 0)
			$display("vector_path_segment_absolutizer_unit test passed");
		else
			$display("vector_path_segment_absolutizer_unit test failed");
		$finish;
	end

endmodule
